// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl of the complex arithmetic unit
// depends on nothing; the using module provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CAU_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define CAU_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CAU_ASSERT_IMP(lbl, pre, post, msg)
`define CAU_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/core/cau_pkg.sv -----
// types, constants and helper functions of the complex arithmetic unit
// no dependencies; used by complex_arithmetic_unit
package cau_pkg;

    // default configuration
    localparam int DEF_FRAC_BITS    = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    // datapath widths
    localparam int DATA_W       = 32;
    localparam int WIDE_W       = 66;
    localparam int PROD_W       = 64;
    localparam int QUO_BITS     = 33;
    localparam int ROOT_BITS    = 32;
    localparam int Z_W          = 40;
    localparam int CORDIC_PRE   = 28;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic        [PROD_W-1:0] uprod_t;
    typedef logic signed [Z_W-1:0]    ang_t;
    typedef logic        [QUO_BITS-1:0]  quo_t;
    typedef logic        [ROOT_BITS-1:0] root_t;

    // angle constants, 32 fraction bits
    localparam ang_t PI_Q32      = 40'sd13493037705;
    localparam ang_t HALF_PI_Q32 = 40'sd6746518852;

    // saturation bounds
    localparam wide_t SAT_MAX = 66'sd2147483647;
    localparam wide_t SAT_MIN = -66'sd2147483648;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_SCALE  = 4'd4,
        OP_NEG    = 4'd5,
        OP_CONJ   = 4'd6,
        OP_RECIP  = 4'd7,
        OP_MAG    = 4'd8,
        OP_ANGLE  = 4'd9,
        OP_DIST   = 4'd10
    } op_t;

    // input register
    typedef struct packed {
        op_t   op;
        data_t ar;
        data_t ai;
        data_t br;
        data_t bi;
        data_t sf;
    } in_t;

    // operand stage
    typedef struct packed {
        op_t               op;
        data_t             a0;
        data_t             b0;
        data_t             a1;
        data_t             b1;
        data_t             a2;
        data_t             b2;
        data_t             a3;
        data_t             b3;
        logic [DATA_W-1:0] sqx;
        logic [DATA_W-1:0] sqy;
        logic              hclip;
        prod_t             cx;
        prod_t             cy;
        ang_t              base;
        logic              aspec;
        ang_t              aspec_val;
        wide_t             dre;
        wide_t             dim;
    } opd_t;

    // product stage
    typedef struct packed {
        op_t    op;
        prod_t  p0;
        prod_t  p1;
        prod_t  p2;
        prod_t  p3;
        uprod_t q0;
        uprod_t q1;
        logic   hclip;
        prod_t  cx;
        prod_t  cy;
        ang_t   base;
        logic   aspec;
        ang_t   aspec_val;
        wide_t  dre;
        wide_t  dim;
    } prd_t;

    // iteration stage: divider, square root and cordic side by side
    typedef struct packed {
        op_t    op;
        uprod_t dv;
        uprod_t r_re;
        uprod_t r_im;
        quo_t   lo_re;
        quo_t   lo_im;
        quo_t   q_re;
        quo_t   q_im;
        logic   neg_re;
        logic   neg_im;
        logic   big_re;
        logic   big_im;
        uprod_t rem;
        root_t  root;
        logic   hclip;
        prod_t  cx;
        prod_t  cy;
        ang_t   z;
        ang_t   base;
        logic   aspec;
        ang_t   aspec_val;
        wide_t  dre;
        wide_t  dim;
    } itr_t;

    typedef struct packed {
        data_t val;
        logic  flag;
    } sat_t;

    // clip to the signed 32-bit range
    function automatic sat_t sat32(input wide_t v);
        sat_t r;
        r.flag = 1'b0;
        r.val  = v[DATA_W-1:0];
        if (v > SAT_MAX)
        begin
            r.flag = 1'b1;
            r.val  = SAT_MAX[DATA_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r.flag = 1'b1;
            r.val  = SAT_MIN[DATA_W-1:0];
        end
        return r;
    endfunction

    // arctangent of 2^-idx, 32 fraction bits
    function automatic ang_t atan_q32(input logic [4:0] idx);
        ang_t r;
        case (idx)
            5'd0:  r = 40'sd3373259426;
            5'd1:  r = 40'sd1991351318;
            5'd2:  r = 40'sd1052175346;
            5'd3:  r = 40'sd534100635;
            5'd4:  r = 40'sd268086748;
            5'd5:  r = 40'sd134174063;
            5'd6:  r = 40'sd67103403;
            5'd7:  r = 40'sd33553749;
            5'd8:  r = 40'sd16777131;
            5'd9:  r = 40'sd8388597;
            5'd10: r = 40'sd4194303;
            5'd11: r = 40'sd2097152;
            5'd12: r = 40'sd1048576;
            5'd13: r = 40'sd524288;
            5'd14: r = 40'sd262144;
            5'd15: r = 40'sd131072;
            5'd16: r = 40'sd65536;
            5'd17: r = 40'sd32768;
            5'd18: r = 40'sd16384;
            5'd19: r = 40'sd8192;
            5'd20: r = 40'sd4096;
            5'd21: r = 40'sd2048;
            5'd22: r = 40'sd1024;
            5'd23: r = 40'sd512;
            5'd24: r = 40'sd256;
            5'd25: r = 40'sd128;
            5'd26: r = 40'sd64;
            5'd27: r = 40'sd32;
            5'd28: r = 40'sd16;
            5'd29: r = 40'sd8;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/complex_arithmetic_unit.sv -----
// complex arithmetic unit: pipelined fixed point complex alu
// depends on cau_pkg and assert_macros.svh
//
//  channel   signals                                          dir  sync
//  operand   operand_valid/ready, operation, a_*, b_*, scale   in   valid/ready
//  result    result_valid/ready, result_re/im, flags           out  valid/ready
//
// one request per cycle while the result is not stalled; an accepted request passes the
// input register (loaded at the accepting edge), operand, product and sum stages, 33 iteration
// stages (one quotient bit each, with root bits and cordic steps in the leading stages) and the output register.
// reset clears only the valid bits; payload registers carry no reset.
// a stalled result freezes the whole pipeline, nothing is dropped or repeated.
`include "assert_macros.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        operand_valid,
    output logic        operand_ready,
    input  logic [3:0]  operation,
    input  data_t       a_re,
    input  data_t       a_im,
    input  data_t       b_re,
    input  data_t       b_im,
    input  data_t       scale_factor,
    output logic        result_valid,
    input  logic        result_ready,
    output data_t       result_re,
    output data_t       result_im,
    output logic        divide_by_zero,
    output logic        saturated
);

    localparam int    N_ITER  = QUO_BITS;
    localparam int    DIV_SH  = QUO_BITS - FRAC_BITS;
    localparam int    ANG_SH  = 32 - FRAC_BITS;
    localparam ang_t  ANG_RND = ang_t'(64'd1 << (31 - FRAC_BITS));
    localparam data_t ONE_Q   = data_t'(64'd1 << FRAC_BITS);

    logic en;

    logic              s1_vld_reg;
    logic              s2_vld_reg;
    logic              s3_vld_reg;
    logic [N_ITER:0]   it_vld_reg;
    logic              result_valid_reg;

    in_t  s1_reg;
    opd_t s2_reg, s2_next;
    prd_t s3_reg, s3_next;
    itr_t it0_next;
    itr_t it_reg [0:N_ITER];

    data_t res_re_reg, res_im_reg;
    logic  dz_reg, sat_reg;

    // pipeline advances unless a finished result is held
    assign en            = !result_valid_reg || result_ready;
    assign operand_ready = en;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            s3_vld_reg       <= 1'b0;
            it_vld_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg       <= operand_valid;
            s2_vld_reg       <= s1_vld_reg;
            s3_vld_reg       <= s2_vld_reg;
            it_vld_reg       <= {it_vld_reg[N_ITER-1:0], s3_vld_reg};
            result_valid_reg <= it_vld_reg[N_ITER];
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.op <= op_t'(operation);
            s1_reg.ar <= a_re;
            s1_reg.ai <= a_im;
            s1_reg.br <= b_re;
            s1_reg.bi <= b_im;
            s1_reg.sf <= scale_factor;
        end
    end

    // operand selection, magnitudes, cordic set-up and simple results
    logic signed [DATA_W:0] hx, hy;
    logic        [DATA_W:0] mx, my;
    prod_t                  xs, ys;

    always_comb
    begin
        s2_next    = '0;
        s2_next.op = s1_reg.op;

        // multiplier operands
        case (s1_reg.op) inside
            OP_MUL:
            begin
                s2_next.a0 = s1_reg.ar; s2_next.b0 = s1_reg.br;
                s2_next.a1 = s1_reg.ai; s2_next.b1 = s1_reg.bi;
                s2_next.a2 = s1_reg.ar; s2_next.b2 = s1_reg.bi;
                s2_next.a3 = s1_reg.ai; s2_next.b3 = s1_reg.br;
            end
            OP_DIV:
            begin
                s2_next.a0 = s1_reg.ar; s2_next.b0 = s1_reg.br;
                s2_next.a1 = s1_reg.ai; s2_next.b1 = s1_reg.bi;
                s2_next.a2 = s1_reg.ai; s2_next.b2 = s1_reg.br;
                s2_next.a3 = s1_reg.ar; s2_next.b3 = s1_reg.bi;
            end
            OP_RECIP:
            begin
                s2_next.a0 = ONE_Q; s2_next.b0 = s1_reg.ar;
                s2_next.a3 = ONE_Q; s2_next.b3 = s1_reg.ai;
            end
            OP_SCALE:
            begin
                s2_next.a0 = s1_reg.ar; s2_next.b0 = s1_reg.sf;
                s2_next.a2 = s1_reg.ai; s2_next.b2 = s1_reg.sf;
            end
            default:
            begin
            end
        endcase

        // squarer inputs: divisor, operand a or difference a-b
        case (s1_reg.op) inside
            OP_DIV:
            begin
                hx = {s1_reg.br[DATA_W-1], s1_reg.br};
                hy = {s1_reg.bi[DATA_W-1], s1_reg.bi};
            end
            OP_DIST:
            begin
                hx = {s1_reg.ar[DATA_W-1], s1_reg.ar} - {s1_reg.br[DATA_W-1], s1_reg.br};
                hy = {s1_reg.ai[DATA_W-1], s1_reg.ai} - {s1_reg.bi[DATA_W-1], s1_reg.bi};
            end
            default:
            begin
                hx = {s1_reg.ar[DATA_W-1], s1_reg.ar};
                hy = {s1_reg.ai[DATA_W-1], s1_reg.ai};
            end
        endcase
        mx = hx[DATA_W] ? unsigned'(-hx) : unsigned'(hx);
        my = hy[DATA_W] ? unsigned'(-hy) : unsigned'(hy);
        s2_next.sqx   = mx[DATA_W-1:0];
        s2_next.sqy   = my[DATA_W-1:0];
        s2_next.hclip = (|mx[DATA_W:DATA_W-1]) || (|my[DATA_W:DATA_W-1]);

        // cordic start: right half plane, base angle for the left half
        xs = prod_t'(s1_reg.ar) <<< CORDIC_PRE;
        ys = prod_t'(s1_reg.ai) <<< CORDIC_PRE;
        s2_next.cx   = s1_reg.ar[DATA_W-1] ? -xs : xs;
        s2_next.cy   = s1_reg.ar[DATA_W-1] ? -ys : ys;
        s2_next.base = '0;
        if (s1_reg.ar[DATA_W-1])
            s2_next.base = (s1_reg.ai > 0) ? PI_Q32 : -PI_Q32;

        // zero components settle the angle directly
        s2_next.aspec     = 1'b0;
        s2_next.aspec_val = '0;
        if (s1_reg.ar == '0)
        begin
            s2_next.aspec = 1'b1;
            if (s1_reg.ai > 0)
                s2_next.aspec_val = HALF_PI_Q32;
            else if (s1_reg.ai < 0)
                s2_next.aspec_val = -HALF_PI_Q32;
        end
        else if (s1_reg.ai == '0)
        begin
            s2_next.aspec = 1'b1;
            if (s1_reg.ar < 0)
                s2_next.aspec_val = PI_Q32;
        end

        // results that need no multiplier
        case (s1_reg.op) inside
            OP_ADD:
            begin
                s2_next.dre = wide_t'(s1_reg.ar) + wide_t'(s1_reg.br);
                s2_next.dim = wide_t'(s1_reg.ai) + wide_t'(s1_reg.bi);
            end
            OP_SUB:
            begin
                s2_next.dre = wide_t'(s1_reg.ar) - wide_t'(s1_reg.br);
                s2_next.dim = wide_t'(s1_reg.ai) - wide_t'(s1_reg.bi);
            end
            OP_NEG:
            begin
                s2_next.dre = -wide_t'(s1_reg.ar);
                s2_next.dim = -wide_t'(s1_reg.ai);
            end
            OP_CONJ:
            begin
                s2_next.dre = wide_t'(s1_reg.ar);
                s2_next.dim = -wide_t'(s1_reg.ai);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_reg <= s2_next;
    end

    // four products and two squares
    always_comb
    begin
        s3_next.op        = s2_reg.op;
        s3_next.p0        = prod_t'(s2_reg.a0) * prod_t'(s2_reg.b0);
        s3_next.p1        = prod_t'(s2_reg.a1) * prod_t'(s2_reg.b1);
        s3_next.p2        = prod_t'(s2_reg.a2) * prod_t'(s2_reg.b2);
        s3_next.p3        = prod_t'(s2_reg.a3) * prod_t'(s2_reg.b3);
        s3_next.q0        = uprod_t'(s2_reg.sqx) * uprod_t'(s2_reg.sqx);
        s3_next.q1        = uprod_t'(s2_reg.sqy) * uprod_t'(s2_reg.sqy);
        s3_next.hclip     = s2_reg.hclip;
        s3_next.cx        = s2_reg.cx;
        s3_next.cy        = s2_reg.cy;
        s3_next.base      = s2_reg.base;
        s3_next.aspec     = s2_reg.aspec;
        s3_next.aspec_val = s2_reg.aspec_val;
        s3_next.dre       = s2_reg.dre;
        s3_next.dim       = s2_reg.dim;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s3_reg <= s3_next;
    end

    // product sums, truncated products and divider set-up
    wide_t                sum_re, sum_im, mw_re, mw_im;
    uprod_t               mag_re, mag_im;
    logic [WIDE_W-1:0]    tr_re, tr_im;
    logic                 ng_re, ng_im;

    always_comb
    begin
        case (s3_reg.op) inside
            OP_DIV, OP_RECIP:
            begin
                sum_re = wide_t'(s3_reg.p0) + wide_t'(s3_reg.p1);
                sum_im = wide_t'(s3_reg.p2) - wide_t'(s3_reg.p3);
            end
            default:
            begin
                sum_re = wide_t'(s3_reg.p0) - wide_t'(s3_reg.p1);
                sum_im = wide_t'(s3_reg.p2) + wide_t'(s3_reg.p3);
            end
        endcase
        ng_re  = sum_re[WIDE_W-1];
        ng_im  = sum_im[WIDE_W-1];
        mw_re  = ng_re ? -sum_re : sum_re;
        mw_im  = ng_im ? -sum_im : sum_im;
        mag_re = mw_re[PROD_W-1:0];
        mag_im = mw_im[PROD_W-1:0];
        tr_re  = {2'b00, mag_re} >> FRAC_BITS;
        tr_im  = {2'b00, mag_im} >> FRAC_BITS;

        it0_next.op     = s3_reg.op;
        it0_next.dv     = s3_reg.q0 + s3_reg.q1;
        it0_next.r_re   = mag_re >> DIV_SH;
        it0_next.r_im   = mag_im >> DIV_SH;
        it0_next.lo_re  = QUO_BITS'(mag_re << FRAC_BITS);
        it0_next.lo_im  = QUO_BITS'(mag_im << FRAC_BITS);
        it0_next.q_re   = '0;
        it0_next.q_im   = '0;
        it0_next.neg_re = ng_re;
        it0_next.neg_im = ng_im;
        it0_next.big_re = 1'b0;
        it0_next.big_im = 1'b0;
        it0_next.rem    = s3_reg.q0 + s3_reg.q1;
        it0_next.root   = '0;
        it0_next.hclip  = s3_reg.hclip;
        it0_next.cx     = s3_reg.cx;
        it0_next.cy     = s3_reg.cy;
        it0_next.z      = '0;
        it0_next.base   = s3_reg.base;
        it0_next.aspec  = s3_reg.aspec;
        it0_next.aspec_val = s3_reg.aspec_val;
        it0_next.dre    = s3_reg.dre;
        it0_next.dim    = s3_reg.dim;
        // products truncated toward zero
        if (s3_reg.op == OP_MUL || s3_reg.op == OP_SCALE)
        begin
            it0_next.dre = ng_re ? -$signed(tr_re) : $signed(tr_re);
            it0_next.dim = ng_im ? -$signed(tr_im) : $signed(tr_im);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            it_reg[0] <= it0_next;
    end

    // iteration stages
    for (genvar k = 0; k < N_ITER; k++)
    begin : g_iter
        localparam int SB = (k < ROOT_BITS) ? ROOT_BITS - 1 - k : 0;

        itr_t              it_next;
        logic [PROD_W:0]   r2_re, r2_im;
        logic [WIDE_W-1:0] trial;
        prod_t             tx, ty;

        always_comb
        begin
            it_next = it_reg[k];

            // quotient overflow seen before the first step
            if (k == 0)
            begin
                it_next.big_re = it_reg[k].r_re >= it_reg[k].dv;
                it_next.big_im = it_reg[k].r_im >= it_reg[k].dv;
            end

            // one restoring division step for each part
            r2_re = {it_reg[k].r_re, it_reg[k].lo_re[QUO_BITS-1]};
            r2_im = {it_reg[k].r_im, it_reg[k].lo_im[QUO_BITS-1]};
            it_next.lo_re = it_reg[k].lo_re << 1;
            it_next.lo_im = it_reg[k].lo_im << 1;
            it_next.q_re  = it_reg[k].q_re << 1;
            it_next.q_im  = it_reg[k].q_im << 1;
            if (r2_re >= {1'b0, it_reg[k].dv})
            begin
                r2_re           = r2_re - {1'b0, it_reg[k].dv};
                it_next.q_re[0] = 1'b1;
            end
            if (r2_im >= {1'b0, it_reg[k].dv})
            begin
                r2_im           = r2_im - {1'b0, it_reg[k].dv};
                it_next.q_im[0] = 1'b1;
            end
            it_next.r_re = r2_re[PROD_W-1:0];
            it_next.r_im = r2_im[PROD_W-1:0];

            // one square root bit, while root bits remain
            trial = (WIDE_W'(it_reg[k].root) << (SB + 1)) + (WIDE_W'(1) << (2 * SB));
            if (k < ROOT_BITS)
            begin
                if ({2'b00, it_reg[k].rem} >= trial)
                begin
                    it_next.rem      = it_reg[k].rem - trial[PROD_W-1:0];
                    it_next.root[SB] = 1'b1;
                end
            end

            // one cordic vectoring step, in the first CORDIC_STEPS stages
            tx = it_reg[k].cx >>> k;
            ty = it_reg[k].cy >>> k;
            if (k < CORDIC_STEPS)
            begin
                if (it_reg[k].cy > 0)
                begin
                    it_next.cx = it_reg[k].cx + ty;
                    it_next.cy = it_reg[k].cy - tx;
                    it_next.z  = it_reg[k].z + atan_q32(5'(k));
                end
                else
                begin
                    it_next.cx = it_reg[k].cx - ty;
                    it_next.cy = it_reg[k].cy + tx;
                    it_next.z  = it_reg[k].z - atan_q32(5'(k));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                it_reg[k+1] <= it_next;
        end
    end

    // result selection and saturation
    ang_t              ang;
    wide_t             ang_w, hyp_w, qv_re, qv_im, re_w, im_w;
    logic [WIDE_W-1:0] qm_re, qm_im;
    logic              dz_next;
    sat_t              sr, si;

    always_comb
    begin
        ang   = it_reg[N_ITER].aspec ? it_reg[N_ITER].aspec_val
                                     : it_reg[N_ITER].base + it_reg[N_ITER].z;
        ang_w = wide_t'((ang + ANG_RND) >>> ANG_SH);
        hyp_w = it_reg[N_ITER].hclip ? wide_t'(66'sd4294967296)
                                     : $signed(WIDE_W'(it_reg[N_ITER].root));
        qm_re = it_reg[N_ITER].big_re ? (WIDE_W'(1) << QUO_BITS)
                                      : WIDE_W'(it_reg[N_ITER].q_re);
        qm_im = it_reg[N_ITER].big_im ? (WIDE_W'(1) << QUO_BITS)
                                      : WIDE_W'(it_reg[N_ITER].q_im);
        qv_re = it_reg[N_ITER].neg_re ? -$signed(qm_re) : $signed(qm_re);
        qv_im = it_reg[N_ITER].neg_im ? -$signed(qm_im) : $signed(qm_im);

        re_w    = '0;
        im_w    = '0;
        dz_next = 1'b0;
        case (it_reg[N_ITER].op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_NEG, OP_CONJ:
            begin
                re_w = it_reg[N_ITER].dre;
                im_w = it_reg[N_ITER].dim;
            end
            OP_DIV, OP_RECIP:
            begin
                if (it_reg[N_ITER].dv == '0)
                    dz_next = 1'b1;
                else
                begin
                    re_w = qv_re;
                    im_w = qv_im;
                end
            end
            OP_MAG, OP_DIST:
            begin
                re_w = hyp_w;
            end
            OP_ANGLE:
            begin
                re_w = ang_w;
            end
            default:
            begin
            end
        endcase
        sr = sat32(re_w);
        si = sat32(im_w);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= sr.val;
            res_im_reg <= si.val;
            dz_reg     <= dz_next;
            sat_reg    <= sr.flag | si.flag;
        end
    end

    assign result_valid   = result_valid_reg;
    assign result_re      = res_re_reg;
    assign result_im      = res_im_reg;
    assign divide_by_zero = dz_reg;
    assign saturated      = sat_reg;

    // checks
    `CAU_ASSERT_NXT(a_accept_enters, operand_valid && operand_ready, s1_vld_reg, "accepted request not in input stage")
    `CAU_ASSERT_NXT(a_stall_freezes, !en, $stable(it_vld_reg) && $stable(s1_vld_reg), "pipeline moved while stalled")
    `CAU_ASSERT_NXT(a_last_to_out, en, result_valid == $past(it_vld_reg[N_ITER]), "last stage not forwarded")
    `CAU_ASSERT_IMP(a_dz_zero, result_valid && divide_by_zero, result_re == '0 && result_im == '0 && !saturated, "divide by zero result not clean")

endmodule
